// File: design/signed_integer_to_radix_digits_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radix digit writer
// Concurrent checks on the core clock, switched off for synthesis.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define SIRDIG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the following cycle.
`define SIRDIG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SIRDIG_ASSERT_IMP(label, ante, cons, msg)
`define SIRDIG_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: design/sirdig_pkg.sv
// ---------------------------------------------------------------------------
// Radix digit writer package
// Widths, character codes, register indexes and shared types.
// ---------------------------------------------------------------------------
package sirdig_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int MAX_SYMBOLS = 16;

  localparam int IN_W      = 32;
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int RADIX_W   = 5;
  localparam int SYM_COUNT = 16;
  localparam int SYM_IDX_W = 4;
  localparam int DIG_W     = $clog2(MAX_SYMBOLS);
  localparam int CNT_W     = $clog2(NUMBER_BITS + 1);
  localparam int STK_W     = NUMBER_BITS * CHAR_W;

  // Divider: STEP_BITS quotient bits per cycle.
  localparam int STEP_BITS = 8;
  localparam int DIV_STEPS = (NUMBER_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W     = DIV_STEPS * STEP_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                   start;
    logic [NUMBER_BITS-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [NUMBER_BITS-1:0] quotient;
    logic [DIG_W-1:0]       remainder;
  } div_res_t;

endpackage

// File: design/signed_integer_to_radix_digits_core.sv
// ---------------------------------------------------------------------------
// Signed integer to radix digits
// Writes a signed number as a word stream of digit characters, most
// significant first, in a radix set by a configured symbol table.
// ---------------------------------------------------------------------------
// Each accepted number leaves as a run of 8-bit character words: a minus sign
// first when the number is negative, then the digits of its magnitude taken
// from the symbol table, with tlast on the final word. The most negative
// number is written with magnitude 2^31. Before any digit is produced the
// table is checked one symbol per cycle; a radix count below 2 or above 16,
// a repeated symbol, or a plus or minus sign among the symbols in use makes
// the number produce no words at all. Digits come from one shared divider
// that divides the magnitude, then each quotient in turn, by the radix,
// giving one digit per division until the quotient is zero. The input is
// not ready while an item is being worked on; the last word may still wait
// in the output register while the next number is taken in.
// ---------------------------------------------------------------------------
`include "signed_integer_to_radix_digits_core_defines.svh"

module signed_integer_to_radix_digits_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // Number input
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic signed [sirdig_pkg::IN_W-1:0] in_tdata,   // [31:0] number
  // Character output
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sirdig_pkg::CHAR_W-1:0]    out_tdata,    // [7:0] character
  output logic                             out_tlast,    // last
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sirdig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sirdig_pkg::CFG_W-1:0]     cfg_data
);
  import sirdig_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0]       sym_low_r;
  logic [CFG_W-1:0]       sym_high_r;
  logic [RADIX_W-1:0]     radix_r;

  // Sequencer state.
  state_t                 state_r, state_nxt;
  logic [NUMBER_BITS-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [SYM_IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]       nd_r, nd_nxt;
  logic [STK_W-1:0]       stack_r, stack_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [CHAR_W-1:0]      sym [SYM_COUNT];
  logic [SYM_IDX_W-1:0]   rd_addr;
  logic [CHAR_W-1:0]      sym_rd;
  logic                   in_accept;
  logic                   slot_free;
  logic                   range_bad;
  logic                   sym_bad;
  logic                   idx_last;
  logic [NUMBER_BITS-1:0] in_value;

  div_req_t               div_req;
  div_res_t               div_res;

  sirdig_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .res_o (div_res)
  );

  // The symbol table unpacked from the two configuration words.
  always_comb begin
    for (int k = 0; k < SYM_COUNT / 2; k++) begin
      sym[k]                 = sym_low_r[k*CHAR_W +: CHAR_W];
      sym[k + SYM_COUNT / 2] = sym_high_r[k*CHAR_W +: CHAR_W];
    end
  end

  // One read port on the table: the symbol under check while checking,
  // otherwise the symbol of the digit the divider has just produced.
  assign rd_addr = (state_r == ST_CHECK) ? idx_r : SYM_IDX_W'(div_res.remainder);
  assign sym_rd  = sym[rd_addr];

  // Table check: the radix count range, and the symbol at idx_r against the signs and every later symbol in use.
  always_comb begin
    range_bad = (radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(MAX_SYMBOLS));
    sym_bad   = (sym_rd == CHAR_PLUS) || (sym_rd == CHAR_MINUS);
    for (int j = 0; j < SYM_COUNT; j++) begin
      if ((SYM_IDX_W'(j) > idx_r) && (RADIX_W'(j) < radix_r) && (sym[j] == sym_rd)) begin
        sym_bad = 1'b1;
      end
    end
    idx_last = (RADIX_W'(idx_r) == (radix_r - RADIX_W'(1)));
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_value  = in_tdata[NUMBER_BITS-1:0];
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt        = state_r;
    mag_nxt          = mag_r;
    neg_nxt          = neg_r;
    idx_nxt          = idx_r;
    nd_nxt           = nd_r;
    stack_nxt        = stack_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_char_nxt     = out_char_r;
    out_last_nxt     = out_last_r;
    div_req.start    = 1'b0;
    div_req.dividend = mag_r;
    div_req.divisor  = radix_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          neg_nxt   = in_value[NUMBER_BITS-1];
          // Two's complement negation also gives 2^31 for the most negative value.
          mag_nxt   = in_value[NUMBER_BITS-1] ? (~in_value + NUMBER_BITS'(1)) : in_value;
          idx_nxt   = '0;
          nd_nxt    = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (range_bad || sym_bad) begin
          state_nxt = ST_IDLE;
        end else if (idx_last) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end else begin
          idx_nxt = idx_r + SYM_IDX_W'(1);
        end
      end
      ST_DIVIDE: begin
        // Digits arrive least significant first and are pushed on a stack,
        // so they pop off most significant first.
        if (div_res.done) begin
          stack_nxt = {stack_r[STK_W-CHAR_W-1:0], sym_rd};
          nd_nxt    = nd_r + CNT_W'(1);
          if (div_res.quotient == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_res.quotient;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = stack_r[CHAR_W-1:0];
            out_last_nxt = (nd_r == CNT_W'(1));
            stack_nxt    = {CHAR_W'(0), stack_r[STK_W-1:CHAR_W]};
            nd_nxt       = nd_r - CNT_W'(1);
            if (nd_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
      sym_low_r   <= '0;
      sym_high_r  <= '0;
      radix_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SYMBOLS_LOW:  sym_low_r  <= cfg_data;
          REG_SYMBOLS_HIGH: sym_high_r <= cfg_data;
          REG_RADIX_COUNT:  radix_r    <= cfg_data[RADIX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    stack_r    <= stack_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // The stack never holds more digits than a magnitude can have.
  `SIRDIG_ASSERT_IMP(a_nd_bound, 1'b1, nd_r <= CNT_W'(NUMBER_BITS), "digit count overflow")
  // Writing out always has a sign or at least one digit left to send.
  `SIRDIG_ASSERT_IMP(a_emit_nonempty, state_r == ST_EMIT, (nd_r != '0) || neg_r, "empty run")
  // The divider only reports while the sequencer waits for it.
  `SIRDIG_ASSERT_IMP(a_div_done_state, div_res.done, state_r == ST_DIVIDE, "stray divider result")
  // Division only starts after the table has passed its check.
  `SIRDIG_ASSERT_NXT(a_div_radix_ok, div_req.start,
                     (radix_r >= RADIX_W'(2)) && (radix_r <= RADIX_W'(MAX_SYMBOLS)),
                     "division with invalid radix")

endmodule

// File: design/sirdig_divider.sv
// ---------------------------------------------------------------------------
// Radix divider
// Long division of the magnitude by the radix, STEP_BITS bits per cycle.
// ---------------------------------------------------------------------------
module sirdig_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sirdig_pkg::div_req_t req_i,
  output sirdig_pkg::div_res_t res_o
);
  import sirdig_pkg::*;

  logic [DIV_W-1:0]     q_r;
  logic [RADIX_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W-1:0]     q_w;
  logic [RADIX_W-1:0]   r_w;
  logic [RADIX_W-1:0]   t_w;

  // The partial remainder stays below the divisor, so it fits one bit less.
  always_comb begin
    q_w = q_r;
    r_w = rem_r;
    t_w = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      t_w = {r_w[RADIX_W-2:0], q_w[DIV_W-1]};
      if (t_w >= req_i.divisor) begin
        r_w = t_w - req_i.divisor;
        q_w = {q_w[DIV_W-2:0], 1'b1};
      end else begin
        r_w = t_w;
        q_w = {q_w[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      q_r   <= DIV_W'(req_i.dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_w;
      rem_r <= r_w;
    end
  end

  assign res_o.done      = done_r;
  assign res_o.quotient  = q_r[NUMBER_BITS-1:0];
  assign res_o.remainder = rem_r[DIG_W-1:0];

endmodule
